// File: rtl/rv2m_pkg.sv
// rv2m_pkg: shared types and constants for the rotation vector to matrix block.
// Used by rv2m_front, rv2m_back and rotation_vector_to_matrix. No dependencies.
package rv2m_pkg;

    // Request handed from the front (norm) to the back (axis, trig, matrix)
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
        logic [19:0]        ang;    // Q.16 radians
    } mid_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } out_t;

    localparam logic [32:0]        HALF_PI_Q32    = 33'd6746518852;
    localparam logic [31:0]        QUARTER_PI_Q32 = 32'd3373259426;
    localparam logic [30:0]        Q30_ONE        = 31'h4000_0000;
    localparam logic signed [15:0] OUT_MAX        = 16'sd16384;

endpackage

// File: rtl/rotation_vector_to_matrix.sv
// rotation_vector_to_matrix: top level, rotation vector in, Rodrigues matrix out.
// Depends on rv2m_pkg, rv2m_front, rv2m_fifo, rv2m_back.
//
//   channel   handshake         payload
//   ------    ---------------   ----------------------------------------
//   input     push / full       rot_x rot_y rot_z  (Q4.12, signed)
//   result    empty / pop       m00 .. m22         (Q1.14, signed)
//
// One request per cycle sustained while no queue is full; every stage is a pipeline register.
// The path runs through 22 front stages (norm and a 20-stage root),
// the front/back queue, 39 back stages (17-stage axis divider, Horner steps,
// matrix products) and the result queue.
// Reset clears only valid bits, queue pointers and queue counts. A full result queue stalls
// the back; a full front/back queue stalls the front and raises full.
module rotation_vector_to_matrix
    import rv2m_pkg::*;
#(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] rot_x,
    input  logic signed [15:0] rot_y,
    input  logic signed [15:0] rot_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);
    logic mid_wr;
    logic mid_full;
    logic mid_empty;
    logic mid_pop;
    mid_t mid_wdata;
    mid_t mid_rdata;
    logic out_wr;
    logic out_full;
    out_t out_wdata;
    out_t out_rdata;

    rv2m_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .rot_x    (rot_x),
        .rot_y    (rot_y),
        .rot_z    (rot_z),
        .mid_wr   (mid_wr),
        .mid_data (mid_wdata),
        .mid_full (mid_full)
    );

    rv2m_fifo #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (mid_wdata),
        .rd_en   (mid_pop),
        .rd_data (mid_rdata),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    rv2m_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_rdata),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (out_wdata)
    );

    rv2m_fifo #(
        .WIDTH ($bits(out_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_wdata),
        .rd_en   (pop && !empty),
        .rd_data (out_rdata),
        .full    (out_full),
        .empty   (empty)
    );

    assign m00 = out_rdata.m00;
    assign m01 = out_rdata.m01;
    assign m02 = out_rdata.m02;
    assign m10 = out_rdata.m10;
    assign m11 = out_rdata.m11;
    assign m12 = out_rdata.m12;
    assign m20 = out_rdata.m20;
    assign m21 = out_rdata.m21;
    assign m22 = out_rdata.m22;

endmodule

// File: rtl/rv2m_fifo.sv
// rv2m_fifo: small register queue with full/empty flags.
// Standalone; used for the front/back queue and the result queue.
module rv2m_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + (AW+1)'(1);
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - (AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!full || rd_en))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("read from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + (AW+1)'(1)))
        else $error("queue count did not advance on write");

endmodule

// File: rtl/rv2m_front.sv
// rv2m_front: takes rotation vectors, forms the squared norm and a pipelined
// integer square root (one result bit per stage). Depends on rv2m_pkg.
module rv2m_front
    import rv2m_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] rot_x,
    input  logic signed [15:0] rot_y,
    input  logic signed [15:0] rot_z,
    output logic               mid_wr,
    output mid_t               mid_data,
    input  logic               mid_full
);
    localparam int SQ_STEPS = 20;
    localparam int NSTG     = SQ_STEPS + 2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               zero;
        logic [39:0]        rad;    // radicand bits still to bring down
        logic [23:0]        rem;
        logic [19:0]        root;
    } sq_t;

    logic               en;
    logic [NSTG-1:0]    vld_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] z_reg;
    sq_t                sq_reg [SQ_STEPS+1];
    sq_t                sq0_next;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] zz;
    logic [31:0]        s2;

    assign en     = !mid_full;
    assign full   = !en;
    assign mid_wr = en && vld_reg[NSTG-1];

    assign mid_data.x    = sq_reg[SQ_STEPS].x;
    assign mid_data.y    = sq_reg[SQ_STEPS].y;
    assign mid_data.z    = sq_reg[SQ_STEPS].z;
    assign mid_data.zero = sq_reg[SQ_STEPS].zero;
    assign mid_data.ang  = sq_reg[SQ_STEPS].root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= rot_x;
            y_reg <= rot_y;
            z_reg <= rot_z;
        end
    end

    assign xx = 32'(x_reg) * 32'(x_reg);
    assign yy = 32'(y_reg) * 32'(y_reg);
    assign zz = 32'(z_reg) * 32'(z_reg);
    assign s2 = unsigned'(xx) + unsigned'(yy) + unsigned'(zz);

    always_comb
    begin
        sq0_next.x    = x_reg;
        sq0_next.y    = y_reg;
        sq0_next.z    = z_reg;
        sq0_next.zero = (s2 == '0);
        sq0_next.rad  = {s2, 8'd0};
        sq0_next.rem  = '0;
        sq0_next.root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= sq0_next;
        end
    end

    // digit-by-digit root: bring down two radicand bits, try (root<<2)|1
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        sq_t         stage_next;
        logic [23:0] acc;
        logic [23:0] trial;

        always_comb
        begin
            stage_next     = sq_reg[i];
            acc            = {sq_reg[i].rem[21:0], sq_reg[i].rad[39:38]};
            trial          = {2'b00, sq_reg[i].root, 2'b01};
            stage_next.rad = {sq_reg[i].rad[37:0], 2'b00};
            if (acc >= trial)
            begin
                stage_next.rem  = acc - trial;
                stage_next.root = {sq_reg[i].root[18:0], 1'b1};
            end
            else
            begin
                stage_next.rem  = acc;
                stage_next.root = {sq_reg[i].root[18:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[i+1] <= stage_next;
            end
        end
    end

endmodule

// File: rtl/rv2m_back.sv
// rv2m_back: axis division, quadrant reduction, sin/cos polynomials and the
// Rodrigues matrix assembly, all pipelined. Depends on rv2m_pkg.
module rv2m_back
    import rv2m_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mid_empty,
    output logic mid_pop,
    input  mid_t mid_data,
    input  logic out_full,
    output logic out_wr,
    output out_t out_data
);
    localparam int DIV_STEPS  = 17;
    localparam int RR_STEPS   = 4;
    localparam int POLY_STEPS = 12;
    localparam int PP_N       = POLY_STEPS + 4;
    localparam int V_PP       = DIV_STEPS + 1;
    localparam int V_TR       = V_PP + PP_N;
    localparam int NSTG       = V_TR + 5;

    localparam logic [6:0] SIN_DIV [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
    localparam logic [6:0] COS_DIV [4] = '{7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] SIN_RCP [4] = '{
        32'(64'd4294967296 / 64'd72), 32'(64'd4294967296 / 64'd42),
        32'(64'd4294967296 / 64'd20), 32'(64'd4294967296 / 64'd6)};
    localparam logic [31:0] COS_RCP [4] = '{
        32'(64'd4294967296 / 64'd56), 32'(64'd4294967296 / 64'd30),
        32'(64'd4294967296 / 64'd12), 32'(64'd4294967296 / 64'd2)};

    typedef struct packed {
        logic [2:0]        sgn;
        logic [2:0][36:0]  rem;
        logic [2:0][16:0]  quo;
        logic [19:0]       ang;
        logic [36:0]       rr_rem;
        logic [3:0]        rr_quo;
        logic              zero;
    } dv_t;

    typedef struct packed {
        logic [2:0][17:0] u;
        logic             zero;
        logic             neg;
        logic [1:0]       quad;
        logic [29:0]      m;
        logic [59:0]      mm;
        logic [29:0]      w;
        logic [30:0]      ps;
        logic [30:0]      pc;
        logic [60:0]      prs;
        logic [60:0]      prc;
        logic [30:0]      ts;
        logic [30:0]      tc;
        logic [62:0]      qms;
        logic [62:0]      qmc;
        logic [60:0]      sprod;
    } pp_t;

    typedef struct packed {
        logic [2:0][17:0]   u;
        logic               zero;
        logic signed [17:0] sv;
        logic [17:0]        vv;
    } tr_t;

    typedef struct packed {
        logic               zero;
        logic signed [35:0] uu00, uu11, uu22, uu01, uu02, uu12;
        logic signed [35:0] su0, su1, su2;
        logic signed [18:0] vv;
    } mx0_t;

    typedef struct packed {
        logic               zero;
        logic signed [36:0] kd0, kd1, kd2;
        logic signed [35:0] uu01, uu02, uu12;
        logic signed [35:0] su0, su1, su2;
        logic signed [18:0] vv;
    } mx1_t;

    typedef struct packed {
        logic               zero;
        logic signed [55:0] vd0, vd1, vd2, v01, v02, v12;
        logic signed [35:0] su0, su1, su2;
    } mx2_t;

    typedef struct packed {
        logic             zero;
        logic [8:0][57:0] e;
    } mx3_t;

    function automatic logic signed [15:0] round_sat(input logic signed [57:0] e);
        logic [57:0] mag;
        logic [23:0] q;
        mag = e[57] ? 58'(-e) : 58'(e);
        q   = 24'((mag + (58'd1 << 33)) >> 34);
        if (q > 24'd16384)
        begin
            q = 24'd16384;
        end
        round_sat = e[57] ? -16'(q) : 16'(q);
    endfunction

    logic            en;
    logic [NSTG-1:0] vld_reg;
    dv_t             dv_reg [DIV_STEPS+1];
    dv_t             dv0_next;
    pp_t             pp_reg [PP_N];
    pp_t             pp0_next;
    pp_t             pp1_next;
    pp_t             pp2_next;
    pp_t             pp15_next;
    tr_t             tr_reg;
    tr_t             tr_next;
    mx0_t            mx0_reg;
    mx0_t            mx0_next;
    mx1_t            mx1_reg;
    mx1_t            mx1_next;
    mx2_t            mx2_reg;
    mx2_t            mx2_next;
    mx3_t            mx3_reg;
    mx3_t            mx3_next;

    assign en      = !out_full;
    assign mid_pop = en && !mid_empty;
    assign out_wr  = en && vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], !mid_empty};
        end
    end

    // ---------------- axis division and quadrant reduction ----------------
    always_comb
    begin
        logic [15:0] mag;
        dv0_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            mag = '0;
            case (c)
                0: mag = mid_data.x[15] ? 16'(-mid_data.x) : 16'(mid_data.x);
                1: mag = mid_data.y[15] ? 16'(-mid_data.y) : 16'(mid_data.y);
                default: mag = mid_data.z[15] ? 16'(-mid_data.z) : 16'(mid_data.z);
            endcase
            dv0_next.rem[c] = (37'(mag) << 20) + 37'(mid_data.ang >> 1);
        end
        dv0_next.sgn    = {mid_data.z[15], mid_data.y[15], mid_data.x[15]};
        dv0_next.ang    = mid_data.ang;
        dv0_next.rr_rem = (37'(mid_data.ang) << 16) + 37'(QUARTER_PI_Q32);
        dv0_next.zero   = mid_data.zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv0_next;
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        localparam int K  = DIV_STEPS - 1 - i;
        localparam int RK = (i < RR_STEPS) ? RR_STEPS - 1 - i : 0;
        dv_t         stage_next;
        logic [36:0] trial;

        always_comb
        begin
            stage_next = dv_reg[i];
            trial      = 37'(dv_reg[i].ang) << K;
            for (int c = 0; c < 3; c++)
            begin
                if (dv_reg[i].rem[c] >= trial)
                begin
                    stage_next.rem[c]    = dv_reg[i].rem[c] - trial;
                    stage_next.quo[c][K] = 1'b1;
                end
            end
            if (i < RR_STEPS)
            begin
                if (dv_reg[i].rr_rem >= (37'(HALF_PI_Q32) << RK))
                begin
                    stage_next.rr_rem     = dv_reg[i].rr_rem - (37'(HALF_PI_Q32) << RK);
                    stage_next.rr_quo[RK] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[i+1] <= stage_next;
            end
        end
    end

    // ---------------- clamp axis, reduced angle ----------------
    always_comb
    begin
        logic [16:0]        qv;
        logic signed [37:0] r;
        logic [37:0]        rmag;
        pp0_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            qv = (dv_reg[DIV_STEPS].quo[c] > 17'd65536) ? 17'd65536
                                                         : dv_reg[DIV_STEPS].quo[c];
            pp0_next.u[c] = dv_reg[DIV_STEPS].sgn[c] ? -(18'(qv)) : 18'(qv);
        end
        // remainder is offset by pi/4, so removing it gives the signed residual
        r             = signed'(38'(dv_reg[DIV_STEPS].rr_rem)) -
                        signed'(38'(QUARTER_PI_Q32));
        rmag          = r[37] ? 38'(-r) : 38'(r);
        pp0_next.zero = dv_reg[DIV_STEPS].zero;
        pp0_next.neg  = r[37];
        pp0_next.quad = dv_reg[DIV_STEPS].rr_quo[1:0];
        pp0_next.m    = rmag[31:2];
    end

    always_comb
    begin
        pp1_next    = pp_reg[0];
        pp1_next.mm = 60'(pp_reg[0].m) * 60'(pp_reg[0].m);
    end

    always_comb
    begin
        pp2_next    = pp_reg[1];
        pp2_next.w  = pp_reg[1].mm[59:30];
        pp2_next.ps = Q30_ONE;
        pp2_next.pc = Q30_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= pp0_next;
            pp_reg[1] <= pp1_next;
            pp_reg[2] <= pp2_next;
        end
    end

    // ---------------- Horner steps: multiply, reciprocal, correct ----------------
    for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
        localparam int ST = j / 3;
        localparam int PH = j % 3;
        pp_t stage_next;

        if (PH == 0) begin : g_mul
            always_comb
            begin
                stage_next     = pp_reg[j+2];
                stage_next.prs = 61'(pp_reg[j+2].w) * 61'(pp_reg[j+2].ps);
                stage_next.prc = 61'(pp_reg[j+2].w) * 61'(pp_reg[j+2].pc);
            end
        end
        else if (PH == 1) begin : g_rcp
            always_comb
            begin
                stage_next     = pp_reg[j+2];
                stage_next.ts  = pp_reg[j+2].prs[60:30];
                stage_next.tc  = pp_reg[j+2].prc[60:30];
                stage_next.qms = 63'(pp_reg[j+2].prs[60:30]) * 63'(SIN_RCP[ST]);
                stage_next.qmc = 63'(pp_reg[j+2].prc[60:30]) * 63'(COS_RCP[ST]);
            end
        end
        else begin : g_fix
            logic [30:0] qs;
            logic [30:0] qc;
            logic [39:0] rs;
            logic [39:0] rc;
            always_comb
            begin
                stage_next = pp_reg[j+2];
                // reciprocal estimate is low by at most one
                qs = pp_reg[j+2].qms[62:32];
                qc = pp_reg[j+2].qmc[62:32];
                rs = 40'(pp_reg[j+2].ts) - 40'(qs) * 40'(SIN_DIV[ST]);
                rc = 40'(pp_reg[j+2].tc) - 40'(qc) * 40'(COS_DIV[ST]);
                if (rs >= 40'(SIN_DIV[ST]))
                begin
                    qs = qs + 31'd1;
                end
                if (rc >= 40'(COS_DIV[ST]))
                begin
                    qc = qc + 31'd1;
                end
                stage_next.ps = Q30_ONE - qs;
                stage_next.pc = Q30_ONE - qc;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[j+3] <= stage_next;
            end
        end
    end

    always_comb
    begin
        pp15_next       = pp_reg[PP_N-2];
        pp15_next.sprod = 61'(pp_reg[PP_N-2].m) * 61'(pp_reg[PP_N-2].ps);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[PP_N-1] <= pp15_next;
        end
    end

    // ---------------- quadrant fold and Q.16 scaling ----------------
    always_comb
    begin
        logic signed [31:0] sn;
        logic signed [31:0] cs;
        logic signed [31:0] sin30;
        logic signed [31:0] cos30;
        logic [31:0]        smag;
        logic [17:0]        sr;
        logic signed [32:0] omc;
        sn = signed'(32'(pp_reg[PP_N-1].sprod[60:30]));
        if (pp_reg[PP_N-1].neg)
        begin
            sn = -sn;
        end
        cs = signed'(32'(pp_reg[PP_N-1].pc));
        case (pp_reg[PP_N-1].quad)
            2'd0:
            begin
                sin30 = sn;
                cos30 = cs;
            end
            2'd1:
            begin
                sin30 = cs;
                cos30 = -sn;
            end
            2'd2:
            begin
                sin30 = -sn;
                cos30 = -cs;
            end
            default:
            begin
                sin30 = -cs;
                cos30 = sn;
            end
        endcase
        smag         = sin30[31] ? 32'(-sin30) : 32'(sin30);
        sr           = 18'((smag + 32'd8192) >> 14);
        tr_next.sv   = sin30[31] ? -signed'(sr) : signed'(sr);
        omc          = signed'(33'(Q30_ONE)) - 33'(cos30);
        tr_next.vv   = 18'(unsigned'(omc + 33'sd8192) >> 14);
        tr_next.u    = pp_reg[PP_N-1].u;
        tr_next.zero = pp_reg[PP_N-1].zero;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_reg <= tr_next;
        end
    end

    // ---------------- matrix assembly ----------------
    always_comb
    begin
        logic signed [35:0] u0;
        logic signed [35:0] u1;
        logic signed [35:0] u2;
        logic signed [35:0] s;
        u0             = 36'(signed'(tr_reg.u[0]));
        u1             = 36'(signed'(tr_reg.u[1]));
        u2             = 36'(signed'(tr_reg.u[2]));
        s              = 36'(tr_reg.sv);
        mx0_next.zero  = tr_reg.zero;
        mx0_next.uu00  = u0 * u0;
        mx0_next.uu11  = u1 * u1;
        mx0_next.uu22  = u2 * u2;
        mx0_next.uu01  = u0 * u1;
        mx0_next.uu02  = u0 * u2;
        mx0_next.uu12  = u1 * u2;
        mx0_next.su0   = s * u0;
        mx0_next.su1   = s * u1;
        mx0_next.su2   = s * u2;
        mx0_next.vv    = signed'({1'b0, tr_reg.vv});
    end

    // diagonal of K^2 is minus the other two squares
    always_comb
    begin
        mx1_next.zero = mx0_reg.zero;
        mx1_next.kd0  = -(37'(mx0_reg.uu11) + 37'(mx0_reg.uu22));
        mx1_next.kd1  = -(37'(mx0_reg.uu00) + 37'(mx0_reg.uu22));
        mx1_next.kd2  = -(37'(mx0_reg.uu00) + 37'(mx0_reg.uu11));
        mx1_next.uu01 = mx0_reg.uu01;
        mx1_next.uu02 = mx0_reg.uu02;
        mx1_next.uu12 = mx0_reg.uu12;
        mx1_next.su0  = mx0_reg.su0;
        mx1_next.su1  = mx0_reg.su1;
        mx1_next.su2  = mx0_reg.su2;
        mx1_next.vv   = mx0_reg.vv;
    end

    always_comb
    begin
        mx2_next.zero = mx1_reg.zero;
        mx2_next.vd0  = 56'(mx1_reg.vv) * 56'(mx1_reg.kd0);
        mx2_next.vd1  = 56'(mx1_reg.vv) * 56'(mx1_reg.kd1);
        mx2_next.vd2  = 56'(mx1_reg.vv) * 56'(mx1_reg.kd2);
        mx2_next.v01  = 56'(mx1_reg.vv) * 56'(mx1_reg.uu01);
        mx2_next.v02  = 56'(mx1_reg.vv) * 56'(mx1_reg.uu02);
        mx2_next.v12  = 56'(mx1_reg.vv) * 56'(mx1_reg.uu12);
        mx2_next.su0  = mx1_reg.su0;
        mx2_next.su1  = mx1_reg.su1;
        mx2_next.su2  = mx1_reg.su2;
    end

    always_comb
    begin
        logic signed [57:0] one48;
        logic signed [57:0] s0;
        logic signed [57:0] s1;
        logic signed [57:0] s2;
        one48         = 58'sd1 <<< 48;
        s0            = 58'(mx2_reg.su0) <<< 16;
        s1            = 58'(mx2_reg.su1) <<< 16;
        s2            = 58'(mx2_reg.su2) <<< 16;
        mx3_next.zero = mx2_reg.zero;
        mx3_next.e[0] = one48 + 58'(mx2_reg.vd0);
        mx3_next.e[1] = 58'(mx2_reg.v01) - s2;
        mx3_next.e[2] = 58'(mx2_reg.v02) + s1;
        mx3_next.e[3] = 58'(mx2_reg.v01) + s2;
        mx3_next.e[4] = one48 + 58'(mx2_reg.vd1);
        mx3_next.e[5] = 58'(mx2_reg.v12) - s0;
        mx3_next.e[6] = 58'(mx2_reg.v02) - s1;
        mx3_next.e[7] = 58'(mx2_reg.v12) + s0;
        mx3_next.e[8] = one48 + 58'(mx2_reg.vd2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx0_reg <= mx0_next;
            mx1_reg <= mx1_next;
            mx2_reg <= mx2_next;
            mx3_reg <= mx3_next;
        end
    end

    // zero vector gives the identity
    always_comb
    begin
        if (mx3_reg.zero)
        begin
            out_data     = '0;
            out_data.m00 = OUT_MAX;
            out_data.m11 = OUT_MAX;
            out_data.m22 = OUT_MAX;
        end
        else
        begin
            out_data.m00 = round_sat(signed'(mx3_reg.e[0]));
            out_data.m01 = round_sat(signed'(mx3_reg.e[1]));
            out_data.m02 = round_sat(signed'(mx3_reg.e[2]));
            out_data.m10 = round_sat(signed'(mx3_reg.e[3]));
            out_data.m11 = round_sat(signed'(mx3_reg.e[4]));
            out_data.m12 = round_sat(signed'(mx3_reg.e[5]));
            out_data.m20 = round_sat(signed'(mx3_reg.e[6]));
            out_data.m21 = round_sat(signed'(mx3_reg.e[7]));
            out_data.m22 = round_sat(signed'(mx3_reg.e[8]));
        end
    end

endmodule

// File: sim/rotation_vector_to_matrix_tb.sv
// Testbench for rotation_vector_to_matrix: fixed-point Rodrigues predictor,
// queue-style drivers on both sides, in-order scoreboard. Depends on rv2m_pkg.
`timescale 1ns / 100ps

module rotation_vector_to_matrix_tb;
    import rv2m_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam longint HALF_PI    = 64'sd6746518852;
    localparam longint ONE30      = 64'sd1073741824;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } rotvec_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic empty;
    logic pop;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    out_t matrix_fifo[$];
    int   errors;
    int   n_sent;
    int   n_checked;
    int   idle_cycles;
    int   push_idle_pct;
    int   pop_idle_pct;
    bit   hold_pop;
    bit   done;

    rotation_vector_to_matrix dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .rot_x (rot_x),
        .rot_y (rot_y),
        .rot_z (rot_z),
        .empty (empty),
        .pop   (pop),
        .m00   (m00),
        .m01   (m01),
        .m02   (m02),
        .m10   (m10),
        .m11   (m11),
        .m12   (m12),
        .m20   (m20),
        .m21   (m21),
        .m22   (m22)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_shift(longint v, int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] sat_entry(longint e48);
        longint e;
        e = round_shift(e48, 34);
        if (e > 16384)
            e = 16384;
        if (e < -16384)
            e = -16384;
        return e[15:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic out_t rodrigues_matrix(rotvec_t rv);
        longint v[3], u[3], kk[3][3], sk[3][3];
        longint s2, ang, big, r, w, m, p, sm, cm, sn, sin30, cos30, sv, vv, mag, qv, e;
        longint q;
        longint ent[9];
        out_t res;
        v[0] = rv.x;
        v[1] = rv.y;
        v[2] = rv.z;
        s2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        if (s2 == 0)
        begin
            res = '0;
            res.m00 = OUT_MAX;
            res.m11 = OUT_MAX;
            res.m22 = OUT_MAX;
            return res;
        end
        ang = int_sqrt(s2 << 8);
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? -v[i] : v[i];
            qv = ((mag << 20) + ang / 2) / ang;
            if (qv > 65536)
                qv = 65536;
            u[i] = (v[i] < 0) ? -qv : qv;
        end
        big = ang << 16;
        q = (big + HALF_PI / 2) / HALF_PI;
        r = big - q * HALF_PI;
        m = ((r < 0) ? -r : r) >>> 2;
        w = (m * m) >>> 30;
        p = ONE30 - w / 72;
        p = ONE30 - ((w * p) >>> 30) / 42;
        p = ONE30 - ((w * p) >>> 30) / 20;
        p = ONE30 - ((w * p) >>> 30) / 6;
        sm = (m * p) >>> 30;
        p = ONE30 - w / 56;
        p = ONE30 - ((w * p) >>> 30) / 30;
        p = ONE30 - ((w * p) >>> 30) / 12;
        cm = ONE30 - ((w * p) >>> 30) / 2;
        sn = (r < 0) ? -sm : sm;
        case (q & 3)
            0: begin sin30 = sn;  cos30 = cm;  end
            1: begin sin30 = cm;  cos30 = -sn; end
            2: begin sin30 = -sn; cos30 = -cm; end
            default: begin sin30 = -cm; cos30 = sn; end
        endcase
        sv = round_shift(sin30, 14);
        vv = round_shift(ONE30 - cos30, 14);
        sk[0][0] = 0;     sk[0][1] = -u[2]; sk[0][2] = u[1];
        sk[1][0] = u[2];  sk[1][1] = 0;     sk[1][2] = -u[0];
        sk[2][0] = -u[1]; sk[2][1] = u[0];  sk[2][2] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                kk[i][j] = (i == j)
                    ? u[i] * u[i] - (u[0] * u[0] + u[1] * u[1] + u[2] * u[2])
                    : u[i] * u[j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                e = (i == j) ? (64'sd1 <<< 48) : 0;
                e += sv * sk[i][j] * 65536;
                e += vv * kk[i][j];
                ent[i * 3 + j] = e;
            end
        res.m00 = sat_entry(ent[0]);
        res.m01 = sat_entry(ent[1]);
        res.m02 = sat_entry(ent[2]);
        res.m10 = sat_entry(ent[3]);
        res.m11 = sat_entry(ent[4]);
        res.m12 = sat_entry(ent[5]);
        res.m20 = sat_entry(ent[6]);
        res.m21 = sat_entry(ent[7]);
        res.m22 = sat_entry(ent[8]);
        return res;
    endfunction

    // Offer one request, with a random leading gap, and hold it until taken.
    // push stays high afterwards so back-to-back requests need no gap.
    task automatic send_vector(rotvec_t rv);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        rot_x <= rv.x;
        rot_y <= rv.y;
        rot_z <= rv.z;
        @(posedge clk);
        while (full)
            @(posedge clk);
        matrix_fifo.push_back(rodrigues_matrix(rv));
        n_sent++;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return $signed(16'($urandom_range(255))) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int count);
        rotvec_t rv;
        for (int i = 0; i < count; i++)
        begin
            rv.x = rand_comp();
            rv.y = rand_comp();
            rv.z = rand_comp();
            send_vector(rv);
        end
    endtask

    task automatic test_directed();
        send_vector('{16'sd0, 16'sd0, 16'sd0});
        send_vector('{16'sd1, 16'sd0, 16'sd0});
        send_vector('{16'sd0, -16'sd1, 16'sd0});
        send_vector('{16'sh7fff, 16'sh7fff, 16'sh7fff});
        send_vector('{16'sh8000, 16'sh8000, 16'sh8000});
        send_vector('{16'sh7fff, 16'sd0, 16'sd0});
        send_vector('{16'sd0, 16'sh8000, 16'sd0});
        send_vector('{16'sd0, 16'sd0, 16'sh7fff});
        send_vector('{16'sd6434, 16'sd0, 16'sd0});   // ~pi/2
        send_vector('{16'sd0, 16'sd12868, 16'sd0});  // ~pi
        send_vector('{16'sd0, 16'sd0, -16'sd19302}); // ~3pi/2
        send_vector('{16'sd25736, 16'sd0, 16'sd0});  // ~2pi
        send_vector('{16'sd3217, 16'sd0, 16'sd0});   // ~pi/4, reduction edge
        send_vector('{16'sd1, 16'sd1, 16'sd1});      // small equal components
        send_vector('{-16'sd1, 16'sd1, -16'sd1});
        send_vector('{16'sh5555, 16'shaaaa, 16'sh5555});
        send_vector('{16'shaaaa, 16'sh5555, 16'shaaaa});
        send_vector('{16'sd4096, 16'sd4096, -16'sd4096});
    endtask

    // Receiver holds off for a long stretch; the pipe fills and full rises.
    task automatic test_backpressure();
        hold_pop = 1'b1;
        fork
            send_random(120);
            begin
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pop = 1'b0;
            end
        join
    endtask

    task automatic wait_drained();
        while (matrix_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                     exp_v, act_v);
            errors++;
        end
    endtask

    // Result side: random pop gaps, in-order comparison on acceptance.
    initial
    begin
        out_t exp_m;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (matrix_fifo.size() == 0)
                begin
                    $display("%0t: unexpected result, m00 %0d", $realtime, m00);
                    errors++;
                end
                else
                begin
                    exp_m = matrix_fifo.pop_front();
                    check_field("m00", exp_m.m00, m00);
                    check_field("m01", exp_m.m01, m01);
                    check_field("m02", exp_m.m02, m02);
                    check_field("m10", exp_m.m10, m10);
                    check_field("m11", exp_m.m11, m11);
                    check_field("m12", exp_m.m12, m12);
                    check_field("m20", exp_m.m20, m20);
                    check_field("m21", exp_m.m21, m21);
                    check_field("m22", exp_m.m22, m22);
                    n_checked++;
                end
            end
            pop <= !hold_pop && ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // Watchdog: cycles without any accepted request on either side.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else if (!done)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout with %0d results outstanding", matrix_fifo.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        hold_pop = 1'b0;
        done = 1'b0;
        push_idle_pct = 14;
        pop_idle_pct = 73;
        rst_n = 1'b0;
        push = 1'b0;
        rot_x = '0;
        rot_y = '0;
        rot_z = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_random(150);
        test_backpressure();
        push_idle_pct = 73;
        pop_idle_pct = 14;
        send_random(120);
        push_idle_pct = 0;
        pop_idle_pct = 0;
        send_random(120);
        push <= 1'b0;
        wait_drained();
        done = 1'b1;

        $display("Sent %0d rotation vectors (edges, quadrants, random), %0d matrices checked",
                 n_sent, n_checked);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
